### rtl/core/rgbled_pkg.sv
// ----------------------------------------------------------------------------
// rgbled_pkg
// shared types and constants for the single-wire rgb led pulse width encoder
// ----------------------------------------------------------------------------
package rgbled_pkg;

    // frame and colour geometry
    localparam int COLOUR_BITS = 24;
    localparam int COLOUR_W    = 24;
    localparam int IDX_W       = 5;
    localparam int SLOT_W      = 7;
    localparam int CFG_W       = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_TDATA_W = 8;

    // slot register reset values
    localparam logic [CFG_W-1:0] ONE_HIGH_RST  = CFG_W'(6);
    localparam logic [CFG_W-1:0] ONE_LOW_RST   = CFG_W'(5);
    localparam logic [CFG_W-1:0] ZERO_HIGH_RST = CFG_W'(4);
    localparam logic [CFG_W-1:0] ZERO_LOW_RST  = CFG_W'(8);

    // item kinds carried on the input tuser
    typedef enum logic
    {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } cmd_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_ONE_HIGH  = 2'd0,
        REG_ONE_LOW   = 2'd1,
        REG_ZERO_HIGH = 2'd2,
        REG_ZERO_LOW  = 2'd3
    } cfg_reg_t;

    // one result item
    typedef struct packed
    {
        logic frame_done;
        logic load_accepted;
        logic busy_res;
        logic line_level;
    } result_t;

    // a zero slot count behaves as one slot
    function automatic logic [CFG_W-1:0] at_least_one(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        r = (v == '0) ? CFG_W'(1) : v;
        return r;
    endfunction

endpackage

### rtl/core/rgb_led_pulse_width_encoder.sv
// ----------------------------------------------------------------------------
// rgb_led_pulse_width_encoder
// single-wire led colour encoder: one line level per tick slot, msb first
// ----------------------------------------------------------------------------
// path: a result passes through the input register, then the result register
// throughput: one item per cycle, set by the bit/slot update, while m_tready
//   does not stall the result register
// reset: rst_n clears all control state asynchronously; slot registers
//   return to 6/5 high/low for a one bit and 4/8 for a zero bit, line idle
module rgb_led_pulse_width_encoder
    import rgbled_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,

    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [COLOUR_W-1:0]    s_tdata,   // colour[23:0]
    input  logic                   s_tuser,   // cmd[0]

    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // line_level, busy_res, load_accepted,
                                              // frame_done, zero pad [7:4]
);

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0] one_high_reg;
    logic [CFG_W-1:0] one_low_reg;
    logic [CFG_W-1:0] zero_high_reg;
    logic [CFG_W-1:0] zero_low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_high_reg  <= ONE_HIGH_RST;
            one_low_reg   <= ONE_LOW_RST;
            zero_high_reg <= ZERO_HIGH_RST;
            zero_low_reg  <= ZERO_LOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ONE_HIGH:  one_high_reg  <= cfg_data;
                REG_ONE_LOW:   one_low_reg   <= cfg_data;
                REG_ZERO_HIGH: zero_high_reg <= cfg_data;
                REG_ZERO_LOW:  zero_low_reg  <= cfg_data;
                default:       one_high_reg  <= one_high_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // pipeline handshake: input register feeds the result register
    // ------------------------------------------------------------------------
    logic                in_vld_reg;
    logic                in_cmd_reg;
    logic [COLOUR_W-1:0] in_colour_reg;
    logic                out_vld_reg;
    result_t             out_res_reg;
    logic                advance;
    logic                in_xfer;

    // stage 1 moves on when the result register is empty or being drained
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_cmd_reg    <= s_tuser;
            in_colour_reg <= s_tdata;
        end
    end

    // ------------------------------------------------------------------------
    // encoder state
    // ------------------------------------------------------------------------
    logic [COLOUR_W-1:0] colour_shift_reg, colour_shift_next;
    logic [IDX_W-1:0]    bit_index_reg,    bit_index_next;
    logic [SLOT_W-1:0]   slot_count_reg,   slot_count_next;
    logic                sending_reg,      sending_next;
    result_t             res_next;

    logic                cur_bit;
    logic [CFG_W-1:0]    hi_slots;
    logic [CFG_W-1:0]    lo_slots;
    logic [SLOT_W-1:0]   total_slots;
    logic [SLOT_W-1:0]   slot_inc;

    // bit positions above the colour width go out as zero bits
    always_comb
    begin
        if (32'(bit_index_reg) < 32'(COLOUR_W))
        begin
            cur_bit = colour_shift_reg[bit_index_reg];
        end
        else
        begin
            cur_bit = 1'b0;
        end
    end

    assign hi_slots    = at_least_one(cur_bit ? one_high_reg : zero_high_reg);
    assign lo_slots    = at_least_one(cur_bit ? one_low_reg  : zero_low_reg);
    assign total_slots = {1'b0, hi_slots} + {1'b0, lo_slots};
    assign slot_inc    = slot_count_reg + SLOT_W'(1);

    always_comb
    begin
        colour_shift_next = colour_shift_reg;
        bit_index_next    = bit_index_reg;
        slot_count_next   = slot_count_reg;
        sending_next      = sending_reg;
        res_next          = '0;

        case (cmd_t'(in_cmd_reg))
            CMD_LOAD:
            begin
                // a load is refused while a frame is still going out
                if (!sending_reg)
                begin
                    colour_shift_next      = in_colour_reg;
                    bit_index_next         = IDX_W'(COLOUR_BITS - 1);
                    slot_count_next        = '0;
                    sending_next           = 1'b1;
                    res_next.load_accepted = 1'b1;
                end
            end
            default:
            begin
                // tick: one time slot of the current bit, high phase first
                if (sending_reg)
                begin
                    res_next.line_level = (slot_count_reg < {1'b0, hi_slots});
                    slot_count_next     = slot_inc;
                    if (slot_inc >= total_slots)
                    begin
                        slot_count_next = '0;
                        if (bit_index_reg == '0)
                        begin
                            sending_next        = 1'b0;
                            res_next.frame_done = 1'b1;
                        end
                        else
                        begin
                            bit_index_next = bit_index_reg - IDX_W'(1);
                        end
                    end
                end
            end
        endcase

        res_next.busy_res = sending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_shift_reg <= '0;
            bit_index_reg    <= '0;
            slot_count_reg   <= '0;
            sending_reg      <= 1'b0;
        end
        else if (advance)
        begin
            colour_shift_reg <= colour_shift_next;
            bit_index_reg    <= bit_index_next;
            slot_count_reg   <= slot_count_next;
            sending_reg      <= sending_next;
        end
    end

    // ------------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 4){1'b0}}, out_res_reg};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    // idle encoder always parks at bit 0, slot 0
    a_idle_parked: assert property (@(posedge clk) disable iff (!rst_n)
        !sending_reg |-> (bit_index_reg == '0 && slot_count_reg == '0))
        else $error("idle encoder not parked");

    // bit index never leaves the frame
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(bit_index_reg) <= 32'(COLOUR_BITS - 1))
        else $error("bit index beyond frame");

    // an accepted load leaves the block busy, a finished frame leaves it idle
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_res_reg.load_accepted) |-> out_res_reg.busy_res)
        else $error("accepted load without busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_res_reg.frame_done) |-> !out_res_reg.busy_res)
        else $error("frame done while still busy");

    // the line only goes high while a frame is in flight
    a_level_busy: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_next.line_level |-> sending_reg)
        else $error("line high while idle");

endmodule

### sim/tb_rgb_led_pulse_width_encoder.sv
// ----------------------------------------------------------------------------
// tb_rgb_led_pulse_width_encoder
// self-checking bench for the single-wire rgb led pulse width encoder: colour
// loads and slot ticks go in on the input stream, every transfer is run
// through a cycle-free predictor, and each result transfer is compared field
// by field with the oldest prediction under random gaps and stalls
// ----------------------------------------------------------------------------
module tb_rgb_led_pulse_width_encoder;

    import rgbled_pkg::*;

    // slot-level predictor of the encoder plus the queue of results still due
    class led_line_scoreboard;
        result_t             due_results[$];
        logic [CFG_W-1:0]    slot_reg [4];
        logic [COLOUR_W-1:0] colour_latch;
        logic [IDX_W-1:0]    bit_pos;
        logic [SLOT_W-1:0]   slot_cnt;
        bit                  sending;
        int                  mismatches;
        int                  results_seen;
        int                  loads_taken;
        int                  loads_refused;
        int                  frames_sent;
        int                  ticks_sent;

        function new();
            slot_reg[REG_ONE_HIGH]  = ONE_HIGH_RST;
            slot_reg[REG_ONE_LOW]   = ONE_LOW_RST;
            slot_reg[REG_ZERO_HIGH] = ZERO_HIGH_RST;
            slot_reg[REG_ZERO_LOW]  = ZERO_LOW_RST;
            colour_latch = '0;
            bit_pos      = '0;
            slot_cnt     = '0;
            sending      = 1'b0;
        endfunction

        function void set_slot_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
            slot_reg[r] = v;
        endfunction

        // a zero length register still gives one slot
        function logic [SLOT_W-1:0] slots_of(logic [CFG_W-1:0] v);
            return (v == '0) ? SLOT_W'(1) : SLOT_W'(v);
        endfunction

        function void note_transfer(cmd_t kind, logic [COLOUR_W-1:0] col);
            result_t           r;
            logic              b;
            logic [SLOT_W-1:0] hi;
            logic [SLOT_W-1:0] lo;
            r = '0;
            if (kind == CMD_LOAD)
            begin
                if (!sending)
                begin
                    colour_latch    = col;
                    bit_pos         = IDX_W'(COLOUR_BITS - 1);
                    slot_cnt        = '0;
                    sending         = 1'b1;
                    r.load_accepted = 1'b1;
                    loads_taken++;
                end
                else
                    loads_refused++;
            end
            else
            begin
                ticks_sent++;
                if (sending)
                begin
                    b  = (bit_pos >= COLOUR_W) ? 1'b0 : colour_latch[bit_pos];
                    hi = slots_of(b ? slot_reg[REG_ONE_HIGH] : slot_reg[REG_ZERO_HIGH]);
                    lo = slots_of(b ? slot_reg[REG_ONE_LOW] : slot_reg[REG_ZERO_LOW]);
                    r.line_level = (slot_cnt < hi);
                    slot_cnt = slot_cnt + 1'b1;
                    if (slot_cnt >= hi + lo)
                    begin
                        slot_cnt = '0;
                        if (bit_pos == '0)
                        begin
                            sending      = 1'b0;
                            r.frame_done = 1'b1;
                            frames_sent++;
                        end
                        else
                            bit_pos = bit_pos - 1'b1;
                    end
                end
            end
            r.busy_res = sending;
            due_results.push_back(r);
        endfunction

        function void report(string what, int want_v, int got_v);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on result %0d: %s expected %0h got %0h",
                         results_seen, what, want_v, got_v);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] word);
            result_t want;
            result_t got;
            got = result_t'(word[3:0]);
            results_seen++;
            if (due_results.size() == 0)
            begin
                report("result with nothing due, word", 0, word);
                return;
            end
            want = due_results.pop_front();
            if (word[OUT_TDATA_W-1:4] !== '0)
                report("pad bits", 0, word[OUT_TDATA_W-1:4]);
            if (got.line_level !== want.line_level)
                report("line_level", want.line_level, got.line_level);
            if (got.busy_res !== want.busy_res)
                report("busy_res", want.busy_res, got.busy_res);
            if (got.load_accepted !== want.load_accepted)
                report("load_accepted", want.load_accepted, got.load_accepted);
            if (got.frame_done !== want.frame_done)
                report("frame_done", want.frame_done, got.frame_done);
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 400000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [COLOUR_W-1:0]    s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    led_line_scoreboard sb;
    int                 items_sent;
    int                 settings_used;
    int                 cycle_count;
    int                 stall_left;
    bit                 quiet;      // phase with no gaps and no stalls at all

    rgb_led_pulse_width_encoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // colour[23:0]
        .s_tuser   (s_tuser),   // cmd[0]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)    // line_level, busy_res, load_accepted, frame_done, pad
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // gap length: mostly none or short, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // slot register values: mostly tiny so frames stay short, zero now and then
    function automatic logic [CFG_W-1:0] random_slots();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return '0;
        else if (r < 80)
            return CFG_W'($urandom_range(1, 3));
        else if (r < 95)
            return CFG_W'($urandom_range(4, 8));
        else
            return CFG_W'($urandom_range(9, 16));
    endfunction

    function automatic logic [COLOUR_W-1:0] pick_colour();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return COLOUR_W'(1) << $urandom_range(0, COLOUR_W - 1);
            3: return ~(COLOUR_W'(1) << $urandom_range(0, COLOUR_W - 1));
            default: return COLOUR_W'($urandom);
        endcase
    endfunction

    // one input transfer; valid stays high into the next item when there is no gap
    task automatic send_item(input cmd_t kind, input logic [COLOUR_W-1:0] col);
        int gap;
        gap = idle_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = col;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_transfer(kind, col);
        items_sent++;
    endtask

    // sender holds off until every predicted result has been seen
    task automatic hold_until_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.due_results.size() > 0)
            @(negedge clk);
    endtask

    // tick until the frame in flight has ended
    task automatic finish_frame();
        while (sb.sending)
            send_item(CMD_TICK, pick_colour());
    endtask

    task automatic write_slot_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = r;
        cfg_data  = v;
        sb.set_slot_reg(r, v);
    endtask

    // new slot lengths, only once the encoder is idle and the pipeline is empty
    task automatic apply_slots(input logic [CFG_W-1:0] oh, input logic [CFG_W-1:0] ol,
                               input logic [CFG_W-1:0] zh, input logic [CFG_W-1:0] zl);
        finish_frame();
        hold_until_drained();
        repeat (4) @(posedge clk);
        write_slot_reg(REG_ONE_HIGH, oh);
        write_slot_reg(REG_ONE_LOW, ol);
        write_slot_reg(REG_ZERO_HIGH, zh);
        write_slot_reg(REG_ZERO_LOW, zl);
        @(negedge clk);
        cfg_we = 1'b0;
        settings_used++;
    endtask

    // one well-formed frame with random content, sometimes cut short
    task automatic random_frame();
        int  cut;
        int  n;
        int  r;
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : 1 << 30;
        n   = 0;
        send_item(CMD_LOAD, pick_colour());
        while (sb.sending && n < cut)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                send_item(CMD_LOAD, pick_colour());     // refused, line keeps going
            else if (r < 5)
                hold_until_drained();
            else
                send_item(CMD_TICK, COLOUR_W'($urandom));
            n++;
        end
        repeat ($urandom_range(0, 2))
            send_item(CMD_TICK, COLOUR_W'($urandom));
    endtask

    // ready side: random stalls of mixed length, none in quiet phases
    initial
    begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready   = 1'b1;
                stall_left = idle_gap();
            end
        end
    end

    // result transfers are taken at the rising edge
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, sb.due_results.size());
            $display("tb_rgb_led_pulse_width_encoder NOT OK");
            $finish;
        end
    end

    initial
    begin
        int phase_items;
        int r;
        sb            = new();
        items_sent    = 0;
        settings_used = 1;
        cycle_count   = 0;
        quiet         = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_ONE_HIGH;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = CMD_TICK;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset slot lengths: tick on an idle line, all-ones colour, load while busy
        send_item(CMD_TICK, '1);
        send_item(CMD_LOAD, '1);
        send_item(CMD_LOAD, '0);
        finish_frame();
        send_item(CMD_TICK, '0);

        // shortest legal lengths, all-zero colour, load straight after frame end
        apply_slots(CFG_W'(1), CFG_W'(1), CFG_W'(1), CFG_W'(1));
        send_item(CMD_LOAD, '0);
        finish_frame();
        send_item(CMD_LOAD, 24'h5a5a5a);
        finish_frame();

        // zero in every register acts as one slot
        apply_slots('0, '0, '0, '0);
        send_item(CMD_LOAD, 24'ha5a5a5);
        send_item(CMD_LOAD, '1);
        finish_frame();
        send_item(CMD_TICK, '1);

        // longest one bit on the first bit of the frame
        apply_slots('1, '1, CFG_W'(1), CFG_W'(1));
        send_item(CMD_LOAD, 24'h800000);
        finish_frame();

        // longest zero bit on the last bit of the frame
        apply_slots(CFG_W'(1), CFG_W'(1), '1, '1);
        send_item(CMD_LOAD, 24'hfffffe);
        finish_frame();

        // random part: phases of fresh slot lengths with random frames and noise
        do
        begin
            quiet = ($urandom_range(0, 3) == 0);
            apply_slots(random_slots(), random_slots(), random_slots(), random_slots());
            phase_items = 0;
            while (phase_items < 40)
            begin
                r = items_sent;
                if ($urandom_range(0, 99) < 80)
                    random_frame();
                else
                    repeat ($urandom_range(1, 6))
                        send_item($urandom_range(0, 1) ? CMD_LOAD : CMD_TICK,
                                  pick_colour());
                phase_items += items_sent - r;
            end
        end
        while (items_sent < 700);
        quiet = 1'b0;

        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.due_results.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d items in %0d slot settings: %0d colours loaded, %0d loads refused",
                 items_sent, settings_used, sb.loads_taken, sb.loads_refused);
        $display("%0d frames sent over %0d ticks, %0d results checked, %0d mismatches",
                 sb.frames_sent, sb.ticks_sent, sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.due_results.size() == 0)
            $display("tb_rgb_led_pulse_width_encoder OK");
        else
            $display("tb_rgb_led_pulse_width_encoder NOT OK");
        $finish;
    end

endmodule

### files.f
rtl/core/rgbled_pkg.sv
rtl/core/rgb_led_pulse_width_encoder.sv
sim/tb_rgb_led_pulse_width_encoder.sv
